// ----- rtl/imaht_pkg.sv -----
package imaht_pkg;

	localparam int MAX_COORDS_DEF = 64;

	localparam int COORD_W = 16;
	localparam int COUNT_W = 7;
	localparam int INDEX_W = 6;
	localparam int SHAPE_W = 3;
	localparam int CFG_W   = 7;

	// input tdata layout, lowest bit first
	localparam int IDX_LSB    = 0;
	localparam int VALUE_LSB  = IDX_LSB + INDEX_W;
	localparam int PX_LSB     = VALUE_LSB + COORD_W;
	localparam int PY_LSB     = PX_LSB + COORD_W;
	localparam int IN_BITS    = PY_LSB + COORD_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_AREA_SHAPE  = 1'b0;
	localparam logic REG_COORD_COUNT = 1'b1;

	localparam logic [SHAPE_W-1:0] SHAPE_UNKNOWN = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_RECT    = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE  = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_POLY    = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_COMPARE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_RECT,
		MODE_POLY,
		MODE_CIRCLE
	} mode_t;

endpackage

// ----- rtl/imaht_store.sv -----
module imaht_store #(
	parameter int DEPTH = imaht_pkg::MAX_COORDS_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [imaht_pkg::COORD_W-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic [imaht_pkg::COORD_W-1:0]     rdata
);

	logic [imaht_pkg::COORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/image_map_area_hit_test_top.sv -----
// Image-map area hit test. A load transfer (tuser = 0) writes one signed 16-bit
// coordinate into the coordinate memory and returns nothing;
// loads to an index at or above MAX_COORDS are dropped. A query transfer
// (tuser = 1) returns one transfer whose bit 0 is 1 when (point_x, point_y)
// lies in the area set by area_shape and coord_count: rectangle (4 coords,
// inclusive), circle (3 coords, dx^2+dy^2 <= r^2) or polygon (even count,
// tested against its inclusive bounding box); shape 0 infers the shape from
// the count. A query walks the memory through its single read port, one
// coordinate per cycle; a circle then squares dx, dy and r in turn through
// the shared 17x17 multiplier, and a query with an unusable shape or count
// skips the walk and goes straight to its result. s_axis_tready is low while
// a query is in work; the result waits in an output register, so the next
// item is taken while it is still unclaimed. Write configuration only while
// the block is idle.
module image_map_area_hit_test_top #(
	parameter int MAX_COORDS = imaht_pkg::MAX_COORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [imaht_pkg::CFG_W-1:0]         cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: coord_index[5:0], coord_value[21:6], point_x[37:22], point_y[53:38], zero pad
	input  logic [imaht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// tuser: func
	input  logic                                s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: inside_res[0], zero pad
	output logic [imaht_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int AW = $clog2(MAX_COORDS);
	localparam int CW = $clog2(MAX_COORDS + 1);
	localparam int CW_ = imaht_pkg::COORD_W;

	// configuration registers
	logic [imaht_pkg::SHAPE_W-1:0] area_shape_q;
	logic [imaht_pkg::COUNT_W-1:0] coord_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_shape_q  <= imaht_pkg::SHAPE_UNKNOWN;
			coord_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imaht_pkg::REG_AREA_SHAPE:  area_shape_q  <= cfg_data[imaht_pkg::SHAPE_W-1:0];
				imaht_pkg::REG_COORD_COUNT: coord_count_q <= cfg_data[imaht_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack input item
	logic [imaht_pkg::INDEX_W-1:0] in_index;
	logic signed [CW_-1:0]         in_value;
	logic signed [CW_-1:0]         in_x;
	logic signed [CW_-1:0]         in_y;

	assign in_index = s_axis_tdata[imaht_pkg::IDX_LSB +: imaht_pkg::INDEX_W];
	assign in_value = s_axis_tdata[imaht_pkg::VALUE_LSB +: CW_];
	assign in_x     = s_axis_tdata[imaht_pkg::PX_LSB +: CW_];
	assign in_y     = s_axis_tdata[imaht_pkg::PY_LSB +: CW_];

	logic in_xfer;
	logic load_xfer;
	logic query_xfer;

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign load_xfer  = in_xfer && (s_axis_tuser == imaht_pkg::FUNC_LOAD);
	assign query_xfer = in_xfer && (s_axis_tuser == imaht_pkg::FUNC_QUERY);

	// shape decision for a new query
	logic [imaht_pkg::SHAPE_W-1:0] eff_shape;
	logic                          query_ok;
	imaht_pkg::mode_t              query_mode;
	logic                          count_ok;

	always_comb begin
		eff_shape = area_shape_q;
		if (area_shape_q == imaht_pkg::SHAPE_UNKNOWN) begin
			priority if (coord_count_q == 7'd4) begin
				eff_shape = imaht_pkg::SHAPE_RECT;
			end else if (coord_count_q == 7'd3) begin
				eff_shape = imaht_pkg::SHAPE_CIRCLE;
			end else if (coord_count_q != '0 && !coord_count_q[0]) begin
				eff_shape = imaht_pkg::SHAPE_POLY;
			end else begin
				eff_shape = imaht_pkg::SHAPE_UNKNOWN;
			end
		end
		count_ok = (coord_count_q != '0) && (32'(coord_count_q) <= 32'(MAX_COORDS));
		query_ok   = 1'b0;
		query_mode = imaht_pkg::MODE_POLY;
		unique case (eff_shape)
			imaht_pkg::SHAPE_RECT: begin
				query_ok   = count_ok && (coord_count_q == 7'd4);
				query_mode = imaht_pkg::MODE_RECT;
			end
			imaht_pkg::SHAPE_CIRCLE: begin
				query_ok   = count_ok && (coord_count_q == 7'd3);
				query_mode = imaht_pkg::MODE_CIRCLE;
			end
			imaht_pkg::SHAPE_POLY: begin
				query_ok   = count_ok && !coord_count_q[0];
				query_mode = imaht_pkg::MODE_POLY;
			end
			default: begin
				query_ok   = 1'b0;
				query_mode = imaht_pkg::MODE_POLY;
			end
		endcase
	end

	// sequencer
	imaht_pkg::state_t state_q;
	imaht_pkg::state_t state_d;
	imaht_pkg::mode_t  mode_q;

	logic [CW-1:0]  n_q;
	logic [CW-1:0]  iss_q;
	logic [CW-1:0]  ridx_s1;
	logic           rvld_s1;
	logic [1:0]     sq_q;
	logic           out_load;
	logic           last_rd;

	assign last_rd  = rvld_s1 && (ridx_s1 == n_q - CW'(1));
	assign out_load = (state_q == imaht_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imaht_pkg::ST_IDLE: begin
				if (query_xfer) begin
					state_d = query_ok ? imaht_pkg::ST_READ : imaht_pkg::ST_DONE;
				end
			end
			imaht_pkg::ST_READ: begin
				if (last_rd) begin
					state_d = (mode_q == imaht_pkg::MODE_CIRCLE) ? imaht_pkg::ST_SQUARE
					                                              : imaht_pkg::ST_COMPARE;
				end
			end
			imaht_pkg::ST_SQUARE: begin
				if (sq_q == 2'd3) begin
					state_d = imaht_pkg::ST_DONE;
				end
			end
			imaht_pkg::ST_COMPARE: state_d = imaht_pkg::ST_DONE;
			imaht_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = imaht_pkg::ST_IDLE;
				end
			end
			default: state_d = imaht_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imaht_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshake and memory controls
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [AW-1:0]  mem_raddr;
	logic [CW_-1:0] mem_rdata;

	always_comb begin
		s_axis_tready = (state_q == imaht_pkg::ST_IDLE);
		mem_we        = load_xfer && (32'(in_index) < 32'(MAX_COORDS));
		mem_waddr     = AW'(in_index);
		mem_raddr     = iss_q[AW-1:0];
	end

	imaht_store #(
		.DEPTH (MAX_COORDS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_value),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// read walk: issue one address a cycle; the registered read data comes back in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			iss_q   <= '0;
			sq_q    <= '0;
		end else begin
			if (state_q == imaht_pkg::ST_READ) begin
				rvld_s1 <= (iss_q < n_q);
				if (iss_q < n_q) begin
					iss_q <= iss_q + CW'(1);
				end
			end else begin
				rvld_s1 <= 1'b0;
				iss_q   <= '0;
			end
			if (state_q == imaht_pkg::ST_SQUARE) begin
				sq_q <= sq_q + 2'd1;
			end else begin
				sq_q <= '0;
			end
		end
	end

	// datapath
	logic signed [CW_-1:0] x_q, y_q;
	logic signed [CW_-1:0] left_q, right_q, top_q, bottom_q;
	logic signed [CW_:0]   dx_q, dy_q, r_q;
	logic signed [CW_:0]   mul_op;
	logic signed [2*CW_+1:0] prod_q;
	logic [2*CW_+2:0]      acc_q;
	logic                  hit_q;
	logic signed [CW_-1:0] rd_val;
	logic signed [CW_:0]   rd_ext;

	assign rd_val = mem_rdata;
	assign rd_ext = {rd_val[CW_-1], rd_val};

	// one multiplier, shared by dx, dy and r
	always_comb begin
		unique case (sq_q)
			2'd0:    mul_op = dx_q;
			2'd1:    mul_op = dy_q;
			default: mul_op = r_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= iss_q;
		if (query_xfer) begin
			x_q    <= in_x;
			y_q    <= in_y;
			mode_q <= query_mode;
			n_q    <= CW'(coord_count_q);
			hit_q  <= 1'b0;
		end
		if (state_q == imaht_pkg::ST_READ && rvld_s1) begin
			unique case (mode_q)
				imaht_pkg::MODE_RECT: begin
					priority if (ridx_s1 == CW'(0)) left_q   <= rd_val;
					else if (ridx_s1 == CW'(1))     top_q    <= rd_val;
					else if (ridx_s1 == CW'(2))     right_q  <= rd_val;
					else                            bottom_q <= rd_val;
				end
				imaht_pkg::MODE_CIRCLE: begin
					priority if (ridx_s1 == CW'(0)) dx_q <= {x_q[CW_-1], x_q} - rd_ext;
					else if (ridx_s1 == CW'(1))     dy_q <= {y_q[CW_-1], y_q} - rd_ext;
					else                            r_q  <= rd_ext;
				end
				default: begin
					// bounding box: even index is x, odd is y; the first pair seeds it
					if (!ridx_s1[0]) begin
						if (ridx_s1 == CW'(0) || rd_val < left_q)  left_q  <= rd_val;
						if (ridx_s1 == CW'(0) || rd_val > right_q) right_q <= rd_val;
					end else begin
						if (ridx_s1 == CW'(1) || rd_val < top_q)    top_q    <= rd_val;
						if (ridx_s1 == CW'(1) || rd_val > bottom_q) bottom_q <= rd_val;
					end
				end
			endcase
		end
		if (state_q == imaht_pkg::ST_SQUARE) begin
			prod_q <= mul_op * mul_op;
			unique case (sq_q)
				2'd1:    acc_q <= {1'b0, prod_q};
				2'd2:    acc_q <= acc_q + {1'b0, prod_q};
				2'd3:    hit_q <= (acc_q <= {1'b0, prod_q});
				default: ;
			endcase
		end
		if (state_q == imaht_pkg::ST_COMPARE) begin
			hit_q <= (x_q >= left_q) && (x_q <= right_q) && (y_q >= top_q) && (y_q <= bottom_q);
		end
	end

	// output register: hold the result until the transfer completes
	logic out_valid_q;
	logic out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= hit_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(imaht_pkg::OUT_TDATA_W-1){1'b0}}, out_data_q};

`ifndef NO_ASSERTIONS
	a_rvld_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_s1 |-> state_q == imaht_pkg::ST_READ)
		else $error("read data valid outside the read walk");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imaht_pkg::ST_READ |-> iss_q <= n_q)
		else $error("read address ran past coordinate count");

	a_square_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imaht_pkg::ST_SQUARE && state_d == imaht_pkg::ST_DONE) |-> sq_q == 2'd3)
		else $error("circle test left before all squares were taken");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |=> !s_axis_tready)
		else $error("ready stayed high after a query");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer |=> state_q == imaht_pkg::ST_IDLE)
		else $error("load moved the sequencer");
`endif

endmodule

// ----- test/image_map_area_hit_test_top_tb.sv -----
// Testbench for image_map_area_hit_test_top.
//
// A short directed table opens the run: queries straight after reset, the
// extremes of the coordinate range against an inclusive rectangle, a circle
// with a wrong count, a plain circle, an odd polygon count, a count above
// the store, the "other" shape and a circle whose squares overflow 32 bits.
// Random phases follow. Each phase picks a shape code and a count (mostly
// well formed, sometimes anything the 7-bit register holds), loads a
// geometry, then fires queries near the shape, on its edges, anywhere, and
// at the corners of the coordinate range, with stray loads mixed in.
//
// Every accepted input transfer goes through the hit-test predictor below;
// a query pushes the expected inside bit and each result transfer is
// compared with the oldest one. The sender works in bursts with random gaps
// and the receiver stalls on its own pattern. Configuration is written only
// with nothing in flight, after the block has had time to settle.
module image_map_area_hit_test_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_COORDS = imaht_pkg::MAX_COORDS_DEF;
	// shape codes the package does not name
	localparam logic [imaht_pkg::SHAPE_W-1:0] SHAPE_OTHER = 3'd4;
	localparam logic [imaht_pkg::SHAPE_W-1:0] SHAPE_NONE  = 3'd7;
	// block settle time after the last expected result
	localparam int SETTLE_CYCLES = 100;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		logic                        reg_sel;
		logic [imaht_pkg::CFG_W-1:0] reg_val;
		logic                        func;
		int                          idx;
		int                          val;
		int                          px;
		int                          py;
		bit                          typed;
		bit                          texp;
	} dir_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic                              cfg_index;
	logic [imaht_pkg::CFG_W-1:0]       cfg_data;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [imaht_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                              s_axis_tuser;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [imaht_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor copy of the area: registers and coordinate store
	logic [imaht_pkg::SHAPE_W-1:0] area_shape_q;
	logic [imaht_pkg::COUNT_W-1:0] coord_count_q;
	logic signed [15:0]            coord_mem [N_COORDS];
	bit                            coord_loaded [N_COORDS];

	// expected inside bits, oldest first
	bit inside_q [$];

	int errors;
	int n_items;
	int burst_left;
	int stall_left;
	int rx_cycles;
	bit rx_calm;
	bit exp_bit;

	image_map_area_hit_test_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] rnd_around(int base, int span);
		return clamp16(base + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Inside bit for a query point against the current area.
	function automatic bit predict_inside(logic signed [15:0] x, logic signed [15:0] y);
		logic [imaht_pkg::SHAPE_W-1:0] shp;
		int n;
		logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
		longint dx, dy, rr;
		n = coord_count_q;
		shp = area_shape_q;
		if (shp == imaht_pkg::SHAPE_UNKNOWN) begin
			if (n == 4)
				shp = imaht_pkg::SHAPE_RECT;
			else if (n == 3)
				shp = imaht_pkg::SHAPE_CIRCLE;
			else if (n != 0 && n % 2 == 0)
				shp = imaht_pkg::SHAPE_POLY;
			else
				shp = SHAPE_NONE;
		end
		if (n == 0 || n > N_COORDS)
			return 1'b0;
		case (shp)
			imaht_pkg::SHAPE_RECT: begin
				if (n != 4)
					return 1'b0;
				lo_x = coord_mem[0];
				lo_y = coord_mem[1];
				hi_x = coord_mem[2];
				hi_y = coord_mem[3];
			end
			imaht_pkg::SHAPE_POLY: begin
				if (n % 2 != 0)
					return 1'b0;
				lo_x = coord_mem[0];
				hi_x = coord_mem[0];
				lo_y = coord_mem[1];
				hi_y = coord_mem[1];
				for (int i = 0; i + 1 < n; i += 2) begin
					if (coord_mem[i] < lo_x) lo_x = coord_mem[i];
					if (coord_mem[i] > hi_x) hi_x = coord_mem[i];
					if (coord_mem[i+1] < lo_y) lo_y = coord_mem[i+1];
					if (coord_mem[i+1] > hi_y) hi_y = coord_mem[i+1];
				end
			end
			imaht_pkg::SHAPE_CIRCLE: begin
				if (n != 3)
					return 1'b0;
				dx = longint'(x) - longint'(coord_mem[0]);
				dy = longint'(y) - longint'(coord_mem[1]);
				rr = longint'(coord_mem[2]);
				return (dx * dx + dy * dy <= rr * rr);
			end
			default: return 1'b0;
		endcase
		return (x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y);
	endfunction

	// Present one item, hold it until the transfer, then update the predictor.
	task automatic send_item(logic func, int idx, logic signed [15:0] val,
			logic signed [15:0] px, logic signed [15:0] py, bit typed, bit texp);
		logic [imaht_pkg::IN_TDATA_W-1:0] word;
		int gap;
		if (cfg_we)
			cfg_we <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		word = '0;
		word[imaht_pkg::IDX_LSB +: imaht_pkg::INDEX_W] = idx[imaht_pkg::INDEX_W-1:0];
		word[imaht_pkg::VALUE_LSB +: imaht_pkg::COORD_W] = val;
		word[imaht_pkg::PX_LSB +: imaht_pkg::COORD_W] = px;
		word[imaht_pkg::PY_LSB +: imaht_pkg::COORD_W] = py;
		s_axis_tdata <= word;
		s_axis_tuser <= func;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_items++;
		if (func == imaht_pkg::FUNC_LOAD) begin
			coord_mem[idx[imaht_pkg::INDEX_W-1:0]] = val;
			coord_loaded[idx[imaht_pkg::INDEX_W-1:0]] = 1'b1;
		end else begin
			inside_q.push_back(typed ? texp : predict_inside(px, py));
		end
	endtask

	// Drop valid, drain every expected result, then let the block settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; cfg_we is lowered by the next item.
	task automatic cfg_write(logic sel, logic [imaht_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		if (sel == imaht_pkg::REG_AREA_SHAPE)
			area_shape_q = val[imaht_pkg::SHAPE_W-1:0];
		else
			coord_count_q = val[imaht_pkg::COUNT_W-1:0];
	endtask

	// Result checker and receiver stall pattern.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (inside_q.size() == 0) begin
				errors++;
				$error("inside_res: expected none, actual %0d", m_axis_tdata[0]);
			end else begin
				exp_bit = inside_q.pop_front();
				if (m_axis_tdata[0] !== exp_bit) begin
					errors++;
					$error("inside_res: expected %0d, actual %0d", exp_bit, m_axis_tdata[0]);
				end
			end
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			// alternate calm stretches with bursts of stalls
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#24_000_000;
		$display("image_map_area_hit_test_top_tb: errors");
		$finish;
	end

	initial begin : main
		dir_row_t dir_tab [36];
		bit prev_item;
		logic [imaht_pkg::SHAPE_W-1:0] shape;
		int count, k, span, base_x, base_y, nq, m, ei, oi;
		logic signed [15:0] gen [N_COORDS];
		logic signed [15:0] tmp, qx, qy;
		bit well_formed, do_geom;

		errors = 0;
		n_items = 0;
		burst_left = 0;
		stall_left = 0;
		rx_cycles = 0;
		rx_calm = 1'b0;
		area_shape_q = imaht_pkg::SHAPE_UNKNOWN;
		coord_count_q = '0;
		for (int i = 0; i < N_COORDS; i++) begin
			coord_mem[i] = '0;
			coord_loaded[i] = 1'b0;
		end

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= imaht_pkg::REG_AREA_SHAPE;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= imaht_pkg::FUNC_LOAD;

		// kind, reg, reg value, func, index, value, x, y, typed, expected
		dir_tab = '{
			// empty area after reset
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 0},
			// full-range rectangle, inferred from a count of four
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 0, -32768, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 1, -32768, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 2, 32767, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 3, 32767, 0, 0, 0, 0},
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 4, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 32767, -32768, 1, 1},
			// small rectangle, inclusive edges
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 0, 10, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 1, 20, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 2, 30, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 3, 40, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 10, 20, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 30, 40, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 30, 41, 0, 0},
			// circle with four coordinates never hits
			'{ROW_CFG, imaht_pkg::REG_AREA_SHAPE, imaht_pkg::SHAPE_CIRCLE,
				imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 20, 30, 1, 0},
			// circle at (10,20), radius 30
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 3, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 40, 20, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 41, 20, 0, 0},
			// the other shape never hits
			'{ROW_CFG, imaht_pkg::REG_AREA_SHAPE, SHAPE_OTHER,
				imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 10, 20, 1, 0},
			// polygon with an odd count
			'{ROW_CFG, imaht_pkg::REG_AREA_SHAPE, imaht_pkg::SHAPE_POLY,
				imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 10, 20, 1, 0},
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 4, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 20, 30, 0, 0},
			// count above the store
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 70, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 20, 30, 1, 0},
			// inferred shape with no coordinates
			'{ROW_CFG, imaht_pkg::REG_AREA_SHAPE, imaht_pkg::SHAPE_UNKNOWN,
				imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 0, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 10, 20, 1, 0},
			// inferred circle whose squares need more than 32 bits
			'{ROW_CFG, imaht_pkg::REG_COORD_COUNT, 3, imaht_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 0, -32768, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 1, -32768, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_LOAD, 2, -32768, 0, 0, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, 32767, 32767, 0, 0},
			'{ROW_ITEM, 0, 0, imaht_pkg::FUNC_QUERY, 0, 0, -32768, -32768, 0, 0}
		};

		// hold reset, then release it for good
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: drain before a register write that follows an item.
		prev_item = 1'b1;
		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				if (prev_item)
					wait_idle();
				cfg_write(dir_tab[r].reg_sel, dir_tab[r].reg_val);
				prev_item = 1'b0;
			end else begin
				send_item(dir_tab[r].func, dir_tab[r].idx, clamp16(dir_tab[r].val),
					clamp16(dir_tab[r].px), clamp16(dir_tab[r].py),
					dir_tab[r].typed, dir_tab[r].texp);
				prev_item = 1'b1;
			end
		end

		// Random phases: one area setting each.
		while (n_items < 1500) begin
			wait_idle();

			m = $urandom_range(0, 15);
			if (m < 13)
				shape = 3'(m % 4);
			else if (m == 13)
				shape = SHAPE_OTHER;
			else
				shape = 3'($urandom_range(5, 7));

			well_formed = ($urandom_range(0, 9) < 7);
			if (well_formed) begin
				case (shape)
					imaht_pkg::SHAPE_RECT:   count = 4;
					imaht_pkg::SHAPE_CIRCLE: count = 3;
					imaht_pkg::SHAPE_POLY:
						count = ($urandom_range(0, 7) == 0) ? 64 : 2 * $urandom_range(1, 8);
					imaht_pkg::SHAPE_UNKNOWN: begin
						case ($urandom_range(0, 2))
							0: count = 4;
							1: count = 3;
							default: count = ($urandom_range(0, 7) == 0) ? 64 :
								2 * $urandom_range(1, 8);
						endcase
					end
					default: count = $urandom_range(0, 64);
				endcase
			end else begin
				case ($urandom_range(0, 5))
					0: count = 0;
					1: count = 64;
					2: count = 65;
					3: count = 127;
					default: count = $urandom_range(0, 127);
				endcase
			end

			if ($urandom_range(0, 1)) begin
				cfg_write(imaht_pkg::REG_AREA_SHAPE, imaht_pkg::CFG_W'(shape));
				cfg_write(imaht_pkg::REG_COORD_COUNT, imaht_pkg::CFG_W'(count));
			end else begin
				cfg_write(imaht_pkg::REG_COORD_COUNT, imaht_pkg::CFG_W'(count));
				cfg_write(imaht_pkg::REG_AREA_SHAPE, imaht_pkg::CFG_W'(shape));
			end

			// pick a window the geometry and most queries fall in
			case ($urandom_range(0, 3))
				0: span = 64;
				1: span = 1000;
				2: span = 12000;
				default: span = 32767;
			endcase
			if (span == 32767) begin
				base_x = 0;
				base_y = 0;
			end else begin
				base_x = int'($urandom_range(0, 60000)) - 30000;
				base_y = int'($urandom_range(0, 60000)) - 30000;
			end

			k = (count > N_COORDS) ? N_COORDS : count;
			for (int i = 0; i < k; i++)
				gen[i] = (i % 2 == 0) ? rnd_around(base_x, span) : rnd_around(base_y, span);
			if (k == 3) begin
				if ($urandom_range(0, 7) == 0)
					gen[2] = clamp16(-int'($urandom_range(0, span)));
				else
					gen[2] = clamp16(int'($urandom_range(0, span)));
			end
			if (k == 4 && $urandom_range(0, 3) != 0) begin
				if (gen[0] > gen[2]) begin
					tmp = gen[0];
					gen[0] = gen[2];
					gen[2] = tmp;
				end
				if (gen[1] > gen[3]) begin
					tmp = gen[1];
					gen[1] = gen[3];
					gen[3] = tmp;
				end
			end

			// load the geometry; always cover entries the queries will read
			do_geom = ($urandom_range(0, 19) < 17);
			for (int i = 0; i < k; i++)
				if (do_geom || !coord_loaded[i])
					send_item(imaht_pkg::FUNC_LOAD, i, gen[i], 16'($urandom),
						16'($urandom), 0, 0);

			nq = $urandom_range(4, 30);
			for (int q = 0; q < nq; q++) begin
				// stray load anywhere in the store
				if ($urandom_range(0, 7) == 0)
					send_item(imaht_pkg::FUNC_LOAD, $urandom_range(0, N_COORDS - 1),
						16'($urandom), 16'($urandom), 16'($urandom), 0, 0);
				m = $urandom_range(0, 19);
				if (m < 12 || (m < 15 && k == 0)) begin
					qx = rnd_around(base_x, span + span / 4 + 2);
					qy = rnd_around(base_y, span + span / 4 + 2);
				end else if (m < 15) begin
					if (k == 3 && $urandom_range(0, 1)) begin
						// on the circle, straight right of the center
						qx = clamp16(int'(coord_mem[0]) + int'(coord_mem[2]));
						qy = coord_mem[1];
					end else begin
						ei = 2 * $urandom_range(0, (k - 1) / 2);
						oi = (ei + 1 < k) ? ei + 1 : ei;
						qx = coord_mem[ei];
						qy = coord_mem[oi];
					end
				end else if (m < 18) begin
					qx = 16'($urandom);
					qy = 16'($urandom);
				end else begin
					case ($urandom_range(0, 2))
						0: qx = -16'sd32768;
						1: qx = 16'sd32767;
						default: qx = '0;
					endcase
					case ($urandom_range(0, 2))
						0: qy = -16'sd32768;
						1: qy = 16'sd32767;
						default: qy = '0;
					endcase
				end
				send_item(imaht_pkg::FUNC_QUERY, $urandom_range(0, N_COORDS - 1),
					16'($urandom), qx, qy, 0, 0);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("image_map_area_hit_test_top_tb: clean");
		else
			$display("image_map_area_hit_test_top_tb: errors");
		$finish;
	end

endmodule
